// ===== rtl/core/anp_pkg.sv =====
// Shared types for the ASCII number parser core.
// No dependencies; imported by anp_step and ascii_number_parser_core.
package anp_pkg;

	typedef enum logic [2:0] {
		PH_START    = 3'd0,
		PH_ZERO     = 3'd1,
		PH_DEC      = 3'd2,
		PH_HEXFIRST = 3'd3,
		PH_HEX      = 3'd4,
		PH_SKIP     = 3'd5
	} phase_t;

	typedef struct packed {
		logic        emit;
		logic        ok;
		logic [31:0] value;
	} result_t;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LX  = 8'h78;
	localparam logic [7:0] CH_UX  = 8'h58;
	localparam logic [7:0] CH_LK  = 8'h6B;
	localparam logic [7:0] CH_UK  = 8'h4B;
	localparam logic [7:0] CH_LM  = 8'h6D;
	localparam logic [7:0] CH_UM  = 8'h4D;

	localparam int KILO_SHIFT = 10;
	localparam int MEGA_SHIFT = 20;

endpackage

// ===== rtl/core/anp_step.sv =====
// Next-state and result logic for one character of the parser.
// Depends on anp_pkg (phase_t, result_t, character codes).
module anp_step import anp_pkg::*; #(
	parameter int MAX_HEX_DIGITS = 8,
	parameter int MAX_DEC_DIGITS = 10,
	parameter int POS_W          = 5
) (
	input  phase_t             phase,
	input  logic [POS_W-1:0]   pos,
	input  logic [31:0]        acc,
	input  logic [7:0]         char_c,
	output phase_t             phase_nxt,
	output logic [POS_W-1:0]   pos_nxt,
	output logic [31:0]        acc_nxt,
	output result_t            res
);

	logic        is_dec;
	logic        is_hex;
	logic [3:0]  hex_val;
	logic        is_k;
	logic        is_m;
	logic        dec_room;
	logic        hex_room;
	logic [31:0] acc_x10;

	always_comb begin
		is_dec  = (char_c inside {[CH_0:CH_9]});
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (char_c inside {[CH_0:CH_9]}) begin
			hex_val = char_c[3:0];
		end else if (char_c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]}) begin
			// 'a'..'f' and 'A'..'F' both end in 1..6
			hex_val = char_c[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
		is_k     = (char_c == CH_LK) || (char_c == CH_UK);
		is_m     = (char_c == CH_LM) || (char_c == CH_UM);
		dec_room = (pos < POS_W'(MAX_DEC_DIGITS));
		hex_room = (pos < POS_W'(MAX_HEX_DIGITS));
		acc_x10  = (acc << 3) + (acc << 1);
	end

	always_comb begin
		phase_nxt = phase;
		pos_nxt   = pos;
		acc_nxt   = acc;
		res       = '0;
		case (phase)
			PH_START: begin
				acc_nxt = '0;
				pos_nxt = '0;
				if (char_c == CH_NUL) begin
					res.emit = 1'b1;
					res.ok   = 1'b1;
				end else if (char_c == CH_0) begin
					pos_nxt   = POS_W'(1);
					phase_nxt = PH_ZERO;
				end else if (is_dec) begin
					acc_nxt   = {28'd0, char_c[3:0]};
					pos_nxt   = POS_W'(1);
					phase_nxt = PH_DEC;
				end else begin
					phase_nxt = PH_SKIP;
					res.emit  = 1'b1;
				end
			end
			PH_ZERO, PH_DEC: begin
				if ((phase == PH_ZERO) && ((char_c == CH_LX) || (char_c == CH_UX))) begin
					acc_nxt   = '0;
					pos_nxt   = '0;
					phase_nxt = PH_HEXFIRST;
				end else if (char_c == CH_NUL) begin
					phase_nxt = PH_START;
					res.emit  = 1'b1;
					res.ok    = 1'b1;
					res.value = acc;
				end else if (is_k) begin
					phase_nxt = PH_SKIP;
					res.emit  = 1'b1;
					res.ok    = 1'b1;
					res.value = acc << KILO_SHIFT;
				end else if (is_m) begin
					phase_nxt = PH_SKIP;
					res.emit  = 1'b1;
					res.ok    = 1'b1;
					res.value = acc << MEGA_SHIFT;
				end else if (is_dec && dec_room) begin
					acc_nxt   = acc_x10 + {28'd0, char_c[3:0]};
					pos_nxt   = pos + 1'b1;
					phase_nxt = PH_DEC;
				end else begin
					phase_nxt = PH_SKIP;
					res.emit  = 1'b1;
				end
			end
			PH_HEXFIRST, PH_HEX: begin
				if (char_c == CH_NUL) begin
					phase_nxt = PH_START;
					res.emit  = 1'b1;
					res.ok    = (phase == PH_HEX);
					res.value = (phase == PH_HEX) ? acc : 32'd0;
				end else if (is_hex && hex_room) begin
					acc_nxt   = {acc[27:0], hex_val};
					pos_nxt   = pos + 1'b1;
					phase_nxt = PH_HEX;
				end else begin
					phase_nxt = PH_SKIP;
					res.emit  = 1'b1;
				end
			end
			default: begin
				// drop characters up to and including the NUL
				if (char_c == CH_NUL) begin
					phase_nxt = PH_START;
				end
			end
		endcase
	end

endmodule

// ===== rtl/core/ascii_number_parser_core.sv =====
// ASCII number parser: one character beat in, at most one result beat out.
// A beat passes the input register, then the result register; both hold while a result is stalled.
// Throughput: one character per cycle unless stalled; the parse state updates in a single pass.
// Reset (arst_n low, asynchronous): parser returns to start of string, both
// pipeline registers empty. Depends on anp_pkg and anp_step.
module ascii_number_parser_core import anp_pkg::*; #(
	parameter int MAX_HEX_DIGITS = 8,
	parameter int MAX_DEC_DIGITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        parse_ok,
	output logic [31:0] number
);

	// Digit counter must hold the larger of the two digit limits.
	localparam int MAX_DIGITS = (MAX_HEX_DIGITS > MAX_DEC_DIGITS) ?
		MAX_HEX_DIGITS : MAX_DEC_DIGITS;
	localparam int POS_W = $clog2(MAX_DIGITS + 1);

	// Input stage
	logic             valid_s1;
	logic [7:0]       char_s1;

	// Parse state
	phase_t           phase_q;
	logic [POS_W-1:0] pos_q;
	logic [31:0]      acc_q;

	// Result stage
	logic             valid_s2;
	logic             ok_s2;
	logic [31:0]      number_s2;

	phase_t           phase_nxt;
	logic [POS_W-1:0] pos_nxt;
	logic [31:0]      acc_nxt;
	result_t          res;
	logic             advance;

	// The whole pipe moves together; hold everything only while a result
	// waits at the output and the sink stalls it.
	assign advance  = !(valid_s2 && out_stall);
	assign in_stall = !advance;

	anp_step #(
		.MAX_HEX_DIGITS (MAX_HEX_DIGITS),
		.MAX_DEC_DIGITS (MAX_DEC_DIGITS),
		.POS_W          (POS_W)
	) u_step (
		.phase     (phase_q),
		.pos       (pos_q),
		.acc       (acc_q),
		.char_c    (char_s1),
		.phase_nxt (phase_nxt),
		.pos_nxt   (pos_nxt),
		.acc_nxt   (acc_nxt),
		.res       (res)
	);

	// Control: input valid, parse state, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_START;
			pos_q    <= '0;
			acc_q    <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1 && res.emit;
			// advance the parse state only on a real character beat
			if (valid_s1) begin
				phase_q <= phase_nxt;
				pos_q   <= pos_nxt;
				acc_q   <= acc_nxt;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (advance) begin
			char_s1   <= char_in;
			ok_s2     <= res.ok;
			number_s2 <= res.value;
		end
	end

	assign out_valid = valid_s2;
	assign parse_ok  = ok_s2;
	assign number    = number_s2;

endmodule
